@@ src/gf_rma_pkg.sv @@
package gf_rma_pkg;

    // Lanes carried on the ports of one item
    localparam int unsigned LANE_COUNT = 4;
    localparam int unsigned ELEM_W     = 8;
    localparam int unsigned COUNT_W    = 3;

    // Low byte of the field polynomial x^8+x^4+x^3+x^2+1
    localparam logic [ELEM_W-1:0] GF_POLY_LOW = 8'h1D;

    typedef enum logic {
        OP_MUL_ADD = 1'b0,
        OP_INVERSE = 1'b1
    } req_op_t;

    typedef logic [ELEM_W-1:0] elem_t;

    typedef struct packed {
        elem_t [LANE_COUNT-1:0] res;
        logic                   last;
    } gf_rma_result_t;

    // Shift-and-add product, reduced by the field polynomial each step
    function automatic elem_t gf_mul(input elem_t x, input elem_t y);
        elem_t a;
        elem_t r;
        a = x;
        r = '0;
        for (int i = 0; i < ELEM_W; i++) begin
            if (y[i]) begin
                r = r ^ a;
            end
            a = a[ELEM_W-1] ? ((a << 1) ^ GF_POLY_LOW) : (a << 1);
        end
        return r;
    endfunction

    typedef elem_t inv_table_t [256];

    // x^254 is the inverse of x for nonzero x and zero for x = 0
    function automatic inv_table_t build_inv_table();
        inv_table_t t;
        elem_t      r;
        for (int x = 0; x < 256; x++) begin
            r = 8'h01;
            for (int k = 0; k < 254; k++) begin
                r = gf_mul(r, elem_t'(x));
            end
            t[x] = r;
        end
        return t;
    endfunction

endpackage

@@ src/gf_rma_lane.sv @@
module gf_rma_lane
    import gf_rma_pkg::*;
(
    input  req_op_t op,
    input  elem_t   coef,
    input  logic    active,
    input  elem_t   acc,
    input  elem_t   src,
    output elem_t   res
);

    localparam inv_table_t INV_TABLE = build_inv_table();

    elem_t product;
    elem_t inverse;

    assign product = gf_mul(coef, src);
    assign inverse = INV_TABLE[src];

    always_comb begin
        res = acc;
        if (active) begin
            case (op)
                OP_MUL_ADD: res = acc ^ product;
                OP_INVERSE: res = inverse;
                default:    res = acc;
            endcase
        end
    end

endmodule

@@ src/gf_rma_merge.sv @@
module gf_rma_merge
    import gf_rma_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  gf_rma_result_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output gf_rma_result_t out_data
);

    logic           main_valid_reg;
    logic           main_valid_next;
    gf_rma_result_t main_data_reg;
    gf_rma_result_t main_data_next;
    logic           skid_valid_reg;
    logic           skid_valid_next;
    gf_rma_result_t skid_data_reg;
    gf_rma_result_t skid_data_next;
    logic           accept;

    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (main_valid_reg && !out_ready) begin
            // hold the output, park a new transfer in the skid slot
            if (accept) begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end else if (skid_valid_reg) begin
            main_valid_next = 1'b1;
            main_data_next  = skid_data_reg;
            skid_valid_next = 1'b0;
        end else begin
            main_valid_next = accept;
            main_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

@@ src/gf256_row_multiply_add_unit.sv @@
// GF(2^8) row multiply-add unit, field polynomial x^8+x^4+x^3+x^2+1.
// Input channel (s_*): one chunk per transfer with up to four byte lanes,
// a coefficient, an operation code, a count of active lanes and a
// last-chunk flag. Operation 0 gives acc ^ coef*src per active lane,
// operation 1 gives the field inverse of src (zero maps to zero).
// Lanes at or above s_lanes_valid, or at or above LANES, return acc.
// A count above LANES counts as all lanes.
// Result channel (m_*): one transfer per input transfer, in order, with
// m_res_last copying the chunk's last flag.
// Results are registered. Throughput: one chunk per cycle while m_ready
// is high; each lane is a combinational XOR multiplier network plus an
// inverse lookup table, all lanes in parallel.
// Stall: a two-entry output stage (output register plus skid slot) keeps
// s_ready registered; one more chunk is taken while a result waits, then
// s_ready drops until the receiver drains.
// Reset (aresetn low, synchronous): both output entries empty, s_ready high.
module gf256_row_multiply_add_unit
    import gf_rma_pkg::*;
#(
    parameter int unsigned LANES = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_coef,
    input  logic [2:0] s_lanes_valid,
    input  logic       s_last_chunk,
    input  logic [7:0] s_acc_0,
    input  logic [7:0] s_acc_1,
    input  logic [7:0] s_acc_2,
    input  logic [7:0] s_acc_3,
    input  logic [7:0] s_src_0,
    input  logic [7:0] s_src_1,
    input  logic [7:0] s_src_2,
    input  logic [7:0] s_src_3,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_res_0,
    output logic [7:0] m_res_1,
    output logic [7:0] m_res_2,
    output logic [7:0] m_res_3,
    output logic       m_res_last
);

    elem_t [LANE_COUNT-1:0] acc;
    elem_t [LANE_COUNT-1:0] src;
    gf_rma_result_t         lane_result;
    gf_rma_result_t         out_result;
    req_op_t                op;

    assign acc = {s_acc_3, s_acc_2, s_acc_1, s_acc_0};
    assign src = {s_src_3, s_src_2, s_src_1, s_src_0};
    assign op  = req_op_t'(s_req_type);

    // One lane core per configured lane; lanes past LANES pass acc through
    for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
        if (i < LANES) begin : g_core
            gf_rma_lane u_lane (
                .op     (op),
                .coef   (s_coef),
                .active (s_lanes_valid > COUNT_W'(i)),
                .acc    (acc[i]),
                .src    (src[i]),
                .res    (lane_result.res[i])
            );
        end else begin : g_pass
            assign lane_result.res[i] = acc[i];
        end
    end

    assign lane_result.last = s_last_chunk;

    // Gather lane results into the registered output with skid slot
    gf_rma_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (lane_result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_res_0    = out_result.res[0];
    assign m_res_1    = out_result.res[1];
    assign m_res_2    = out_result.res[2];
    assign m_res_3    = out_result.res[3];
    assign m_res_last = out_result.last;

endmodule
